// ===== rtl/wcs_pkg.sv =====
// Shared types and constants of the wavelength channel scheduler.
`default_nettype none

package wcs_pkg;

	// Default sizes, handed down as top-level parameter defaults
	localparam int PORTS_DEF     = 8;
	localparam int MAX_WL_DEF    = 16;
	localparam int TIME_BITS_DEF = 48;

	// Fixed widths of the beat fields
	localparam int FLD_TIME_W = 48;
	localparam int FLD_PORT_W = 3;
	localparam int FLD_LEN_W  = 24;
	localparam int FLD_WL_W   = 5;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int GUARD_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WL_IN_USE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GUARD     = 4'd1;

	localparam logic [FLD_WL_W-1:0] WL_IN_USE_RST = 5'd16;
	localparam logic [GUARD_W-1:0]  GUARD_RST     = 16'd0;

	// Search token control handed from cell to cell
	typedef struct packed {
		logic vld;
		logic found;
	} tok_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/wavelength_channel_scheduler.sv =====
// Top level: request sequencer, cell chain, end-time arithmetic and output register.
// Each request runs launch, search, start, end and write-back in turn; the search token walks
// the wavelength cells one per cycle. A new request is taken only once the sequencer is idle
// again, so requests do not overlap in the chain.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low) clears control and every cell's written flags at once: all channels
// read as free right after reset, with no clearing pass; registers go to 16 and 0.
`default_nettype none

module wavelength_channel_scheduler import wcs_pkg::*; #(
	parameter int PORTS           = PORTS_DEF,
	parameter int MAX_WAVELENGTHS = MAX_WL_DEF,
	parameter int TIME_BITS       = TIME_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	// request channel
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire [FLD_TIME_W-1:0]    now_tick,
	input  wire [FLD_PORT_W-1:0]    out_port,
	input  wire [FLD_LEN_W-1:0]     offset_ticks,
	input  wire [FLD_LEN_W-1:0]     burst_ticks,
	// result channel
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [FLD_WL_W-1:0]     wavelength,
	output logic [FLD_TIME_W-1:0]   header_delay,
	output logic [FLD_TIME_W-1:0]   reserve_start,
	output logic [FLD_TIME_W-1:0]   reserve_end,
	// configuration write channel
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire [CFG_IDX_W-1:0]     cfg_index,
	input  wire [CFG_DATA_W-1:0]    cfg_data
);

	localparam int PORT_W = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam int WL_W   = (MAX_WAVELENGTHS > 1) ? $clog2(MAX_WAVELENGTHS) : 1;
	localparam int CNT_W  = $clog2(MAX_WAVELENGTHS+1);
	localparam int CW     = (TIME_BITS > FLD_TIME_W) ? TIME_BITS : FLD_TIME_W;
	localparam logic [CW+1:0] TMAX = (CW+2)'((66'd1 << TIME_BITS) - 66'd1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAUNCH,
		S_SRCH,
		S_START,
		S_END,
		S_WB
	} state_t;

	// Port number wraps modulo PORTS; input is three bits so a few subtracts do
	function automatic logic [PORT_W-1:0] port_wrap(input logic [FLD_PORT_W-1:0] p);
		logic [6:0] v;
		v = 7'(p);
		for (int k = 0; k < 8; k++) begin
			if (v >= 7'(PORTS)) begin
				v = v - 7'(PORTS);
			end
		end
		return PORT_W'(v);
	endfunction

	// a + b + c clamped to the largest time value
	function automatic logic [CW-1:0] sat3(input logic [CW-1:0] a, input logic [CW-1:0] b,
		input logic [CW-1:0] c);
		logic [CW+1:0] s;
		s = (CW+2)'(a) + (CW+2)'(b) + (CW+2)'(c);
		if (s > TMAX) begin
			return CW'(TMAX);
		end
		return CW'(s);
	endfunction

	state_t                  state_q;
	logic [FLD_WL_W-1:0]     wl_cfg_q;
	logic [GUARD_W-1:0]      guard_q;
	logic [CNT_W-1:0]        cnt_eff;
	logic                    accept;
	logic                    out_free;
	logic [PORT_W-1:0]       in_port_w;

	// request context and arithmetic
	logic [CW-1:0]           now_q;
	logic [PORT_W-1:0]       port_q;
	logic [FLD_LEN_W-1:0]    off_q;
	logic [FLD_LEN_W-1:0]    burst_q;
	logic                    found_q;
	logic [WL_W-1:0]         best_q;
	logic [TIME_BITS-1:0]    bend_q;
	logic [CW-1:0]           delay_q;
	logic [CW-1:0]           start_q;
	logic [CW-1:0]           end_q;
	logic [CW-1:0]           wait_t;
	logic [CW-1:0]           delay_nxt;
	logic [WL_W:0]           wl_num;
	logic                    wr_en;

	// cell chain
	tok_ctl_t                tok   [MAX_WAVELENGTHS+1];
	logic [WL_W-1:0]         tbest [MAX_WAVELENGTHS+1];
	logic [TIME_BITS-1:0]    tbend [MAX_WAVELENGTHS+1];
	logic [MAX_WAVELENGTHS:0] tok_vld;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign cfg_ready = 1'b1;
	assign in_port_w = port_wrap(out_port);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_cfg_q <= WL_IN_USE_RST;
			guard_q  <= GUARD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WL_IN_USE: wl_cfg_q <= cfg_data[FLD_WL_W-1:0];
				REG_GUARD:     guard_q  <= cfg_data[GUARD_W-1:0];
				default: ;
			endcase
		end
	end

	// Searched wavelength count: zero counts as one, large values saturate
	always_comb begin
		if (wl_cfg_q == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (int'(wl_cfg_q) > MAX_WAVELENGTHS) begin
			cnt_eff = CNT_W'(MAX_WAVELENGTHS);
		end else begin
			cnt_eff = CNT_W'(wl_cfg_q);
		end
	end

	// Chain head: fresh token launched once the column read is back
	assign tok[0]   = '{vld: (state_q == S_LAUNCH), found: 1'b0};
	assign tbest[0] = '0;
	assign tbend[0] = '0;

	for (genvar g = 0; g < MAX_WAVELENGTHS; g++) begin : g_cell
		wcs_cell #(
			.PORTS           (PORTS),
			.MAX_WAVELENGTHS (MAX_WAVELENGTHS),
			.TIME_BITS       (TIME_BITS),
			.IDX             (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.rd_en    (accept),
			.rd_port  (in_port_w),
			.wr_en    (wr_en),
			.wr_sel   (best_q),
			.wr_port  (port_q),
			.wr_data  (TIME_BITS'(end_q)),
			.now      (now_q),
			.cnt      (cnt_eff),
			.tok_in   (tok[g]),
			.best_in  (tbest[g]),
			.bend_in  (tbend[g]),
			.tok_out  (tok[g+1]),
			.best_out (tbest[g+1]),
			.bend_out (tbend[g+1])
		);
	end

	for (genvar g = 0; g <= MAX_WAVELENGTHS; g++) begin : g_tokv
		assign tok_vld[g] = tok[g].vld;
	end

	// Header delay from the search result at the chain tail
	always_comb begin
		wait_t = CW'(tbend[MAX_WAVELENGTHS]) - now_q;
		if (tok[MAX_WAVELENGTHS].found) begin
			delay_nxt = '0;
		end else if (wait_t > CW'(off_q)) begin
			delay_nxt = wait_t - CW'(off_q);
		end else begin
			delay_nxt = '0;
		end
	end

	// Book the channel only if the new end is later
	assign wr_en  = (state_q == S_WB) && out_free && (end_q > CW'(bend_q));
	assign wl_num = (WL_W+1)'(best_q) + (WL_W+1)'(1);

	// Request datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q   <= CW'(now_tick);
			port_q  <= in_port_w;
			off_q   <= offset_ticks;
			burst_q <= burst_ticks;
		end
		if ((state_q == S_SRCH) && tok[MAX_WAVELENGTHS].vld) begin
			found_q <= tok[MAX_WAVELENGTHS].found;
			best_q  <= tbest[MAX_WAVELENGTHS];
			bend_q  <= tbend[MAX_WAVELENGTHS];
			delay_q <= delay_nxt;
		end
		if (state_q == S_START) begin
			start_q <= sat3(now_q, delay_q, CW'(off_q));
		end
		if (state_q == S_END) begin
			end_q <= sat3(start_q, CW'(burst_q), CW'(guard_q));
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid     <= 1'b0;
			wavelength    <= '0;
			header_delay  <= '0;
			reserve_start <= '0;
			reserve_end   <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LAUNCH;
					end
				end
				S_LAUNCH: state_q <= S_SRCH;
				S_SRCH: begin
					if (tok[MAX_WAVELENGTHS].vld) begin
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_END;
				S_END:   state_q <= S_WB;
				S_WB: begin
					if (out_free) begin
						out_valid     <= 1'b1;
						wavelength    <= FLD_WL_W'(wl_num);
						header_delay  <= delay_q[FLD_TIME_W-1:0];
						reserve_start <= start_q[FLD_TIME_W-1:0];
						reserve_end   <= end_q[FLD_TIME_W-1:0];
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The token reaches the chain tail only while the sequencer waits for it
	a_tail_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		tok[MAX_WAVELENGTHS].vld |-> (state_q == S_SRCH))
		else $error("search token left the chain outside the search phase");

	// At most one request is ever in the chain
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one search token in the cell chain");

	// A free channel never carries a header delay
	a_free_no_delay: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START) |-> (!found_q || (delay_q == '0)))
		else $error("free channel chosen with nonzero header delay");

	// The booked end never precedes the burst start
	a_end_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB) |-> (end_q >= start_q))
		else $error("reservation end before reservation start");
`endif

endmodule

`default_nettype wire

// ===== rtl/wcs_cell.sv =====
// One wavelength cell: busy-until column for all ports plus one search step.
`default_nettype none

module wcs_cell import wcs_pkg::*; #(
	parameter int PORTS           = PORTS_DEF,
	parameter int MAX_WAVELENGTHS = MAX_WL_DEF,
	parameter int TIME_BITS       = TIME_BITS_DEF,
	parameter int IDX             = 0
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// column read, one port per request
	input  wire                                    rd_en,
	input  wire [((PORTS > 1) ? $clog2(PORTS) : 1)-1:0] rd_port,
	// write-back of the chosen channel
	input  wire                                    wr_en,
	input  wire [((MAX_WAVELENGTHS > 1) ? $clog2(MAX_WAVELENGTHS) : 1)-1:0] wr_sel,
	input  wire [((PORTS > 1) ? $clog2(PORTS) : 1)-1:0] wr_port,
	input  wire [TIME_BITS-1:0]                    wr_data,
	// request context
	input  wire [((TIME_BITS > FLD_TIME_W) ? TIME_BITS : FLD_TIME_W)-1:0] now,
	input  wire [$clog2(MAX_WAVELENGTHS+1)-1:0]    cnt,
	// search token from the lower neighbor
	input  tok_ctl_t                               tok_in,
	input  wire [((MAX_WAVELENGTHS > 1) ? $clog2(MAX_WAVELENGTHS) : 1)-1:0] best_in,
	input  wire [TIME_BITS-1:0]                    bend_in,
	// search token to the upper neighbor
	output tok_ctl_t                               tok_out,
	output logic [((MAX_WAVELENGTHS > 1) ? $clog2(MAX_WAVELENGTHS) : 1)-1:0] best_out,
	output logic [TIME_BITS-1:0]                   bend_out
);

	localparam int WL_W   = (MAX_WAVELENGTHS > 1) ? $clog2(MAX_WAVELENGTHS) : 1;
	localparam int CNT_W  = $clog2(MAX_WAVELENGTHS+1);
	localparam int CW     = (TIME_BITS > FLD_TIME_W) ? TIME_BITS : FLD_TIME_W;

	logic [TIME_BITS-1:0] mem [PORTS];
	logic [PORTS-1:0]     vld_q;
	logic [TIME_BITS-1:0] rd_mem_q;
	logic                 rd_vld_q;
	logic [TIME_BITS-1:0] row;
	logic                 active;
	logic                 wr_hit;
	tok_ctl_t             tok_nxt;
	logic [WL_W-1:0]      best_nxt;
	logic [TIME_BITS-1:0] bend_nxt;
	tok_ctl_t             tok_q;
	logic [WL_W-1:0]      best_q;
	logic [TIME_BITS-1:0] bend_q;

	assign wr_hit = wr_en && (wr_sel == WL_W'(IDX));

	// Column storage, registered read
	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[wr_port] <= wr_data;
		end
		if (rd_en) begin
			rd_mem_q <= mem[rd_port];
		end
	end

	// Written-since-reset flags; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_hit) begin
				vld_q[wr_port] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_port];
			end
		end
	end

	assign row    = rd_vld_q ? rd_mem_q : '0;
	assign active = CNT_W'(IDX) < cnt;

	// Search step: first free wins, else earliest end, ties to lower index
	always_comb begin
		tok_nxt  = tok_in;
		best_nxt = best_in;
		bend_nxt = bend_in;
		if (tok_in.vld && active && !tok_in.found) begin
			if (CW'(row) <= now) begin
				tok_nxt.found = 1'b1;
				best_nxt      = WL_W'(IDX);
				bend_nxt      = row;
			end else if ((IDX == 0) || (row < bend_in)) begin
				best_nxt = WL_W'(IDX);
				bend_nxt = row;
			end
		end
	end

	// Token control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	// Token payload
	always_ff @(posedge clk) begin
		best_q <= best_nxt;
		bend_q <= bend_nxt;
	end

	assign tok_out  = tok_q;
	assign best_out = best_q;
	assign bend_out = bend_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the wavelength channel scheduler: reservation book and stimulus.
`timescale 1ns / 100ps

import wcs_pkg::*;

localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS_DEF) - 64'd1;

typedef struct {
	logic [FLD_WL_W-1:0]   wl;
	logic [FLD_TIME_W-1:0] delay;
	logic [FLD_TIME_W-1:0] start;
	logic [FLD_TIME_W-1:0] stop;
} grant_t;

// Channel occupancy per port and wavelength, plus the grants still owed by the block
class reservation_book;
	logic [TIME_BITS_DEF-1:0] busy_until [PORTS_DEF][MAX_WL_DEF];
	logic [FLD_WL_W-1:0]      wl_count;
	logic [GUARD_W-1:0]       guard;
	grant_t                   owed_grants[$];
	int unsigned              mismatches;

	function new();
		for (int p = 0; p < PORTS_DEF; p++)
			for (int w = 0; w < MAX_WL_DEF; w++)
				busy_until[p][w] = '0;
		wl_count = WL_IN_USE_RST;
		guard = GUARD_RST;
		mismatches = 0;
	endfunction

	function void write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		case (index)
			REG_WL_IN_USE: wl_count = data[FLD_WL_W-1:0];
			REG_GUARD: guard = data[GUARD_W-1:0];
			default: ;
		endcase
	endfunction

	// Time sum clipped at the top of the time range
	function logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] sum;
		sum = a + b;
		return (sum > TIME_MAX) ? TIME_MAX : sum;
	endfunction

	// First-fit search, header delay and booking for one request
	function void note_request(input logic [FLD_TIME_W-1:0] now,
			input logic [FLD_PORT_W-1:0] port, input logic [FLD_LEN_W-1:0] offset,
			input logic [FLD_LEN_W-1:0] burst);
		int unsigned row, count, i, pick;
		logic [63:0] pick_end, gap, delay, start, stop, held;
		bit found;
		grant_t g;
		row = port % PORTS_DEF;
		count = wl_count;
		if (count == 0)
			count = 1;
		if (count > MAX_WL_DEF)
			count = MAX_WL_DEF;
		pick = 0;
		pick_end = '0;
		found = 1'b0;
		for (i = 0; i < count; i++) begin
			held = 64'(busy_until[row][i]);
			if (!found) begin
				if (held <= 64'(now)) begin
					pick = i;
					found = 1'b1;
				end else if (i == 0 || held < pick_end) begin
					pick = i;
					pick_end = held;
				end
			end
		end
		delay = '0;
		if (!found) begin
			gap = pick_end - 64'(now);
			delay = (gap > 64'(offset)) ? gap - 64'(offset) : 64'd0;
		end
		start = add_sat(add_sat(64'(now), delay), 64'(offset));
		stop = add_sat(add_sat(start, 64'(burst)), 64'(guard));
		// channel keeps the later end
		if (stop > 64'(busy_until[row][pick]))
			busy_until[row][pick] = stop[TIME_BITS_DEF-1:0];
		g.wl = FLD_WL_W'(pick + 1);
		g.delay = delay[FLD_TIME_W-1:0];
		g.start = start[FLD_TIME_W-1:0];
		g.stop = stop[FLD_TIME_W-1:0];
		owed_grants.push_back(g);
	endfunction

	function void check_grant(input grant_t got);
		grant_t want;
		if (owed_grants.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: grant with none owed: wl %0d delay %0h start %0h end %0h",
					$time, got.wl, got.delay, got.start, got.stop);
			return;
		end
		want = owed_grants.pop_front();
		if (got.wl !== want.wl || got.delay !== want.delay || got.start !== want.start
				|| got.stop !== want.stop) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: grant mismatch: wl %0d/%0d delay %0h/%0h start %0h/%0h end %0h/%0h",
					$time, want.wl, got.wl, want.delay, got.delay, want.start, got.start,
					want.stop, got.stop);
		end
	endfunction

	function int unsigned outstanding();
		return owed_grants.size();
	endfunction

	function int unsigned failures();
		return mismatches + owed_grants.size();
	endfunction
endclass

module tb_top;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned PHASE_ITEMS = 150;
	localparam int unsigned SETTLE_CYCLES = 30;
	// indexes past the register list, written to show they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 4'd15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FLD_TIME_W-1:0] now_tick = '0;
	logic [FLD_PORT_W-1:0] out_port = '0;
	logic [FLD_LEN_W-1:0] offset_ticks = '0;
	logic [FLD_LEN_W-1:0] burst_ticks = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [FLD_WL_W-1:0] wavelength;
	logic [FLD_TIME_W-1:0] header_delay;
	logic [FLD_TIME_W-1:0] reserve_start;
	logic [FLD_TIME_W-1:0] reserve_end;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	reservation_book book;
	int unsigned sender_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned cycle_count = 0;
	logic [FLD_TIME_W-1:0] traffic_now = '0;

	wavelength_channel_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_tick(now_tick),
		.out_port(out_port),
		.offset_ticks(offset_ticks),
		.burst_ticks(burst_ticks),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.wavelength(wavelength),
		.header_delay(header_delay),
		.reserve_start(reserve_start),
		.reserve_end(reserve_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Random receiver backpressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// Beat monitor: check grants, book accepted requests
	always @(posedge clk) begin
		grant_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.wl = wavelength;
				got.delay = header_delay;
				got.start = reserve_start;
				got.stop = reserve_end;
				book.check_grant(got);
			end
			if (in_valid && !in_stall)
				book.note_request(now_tick, out_port, offset_ticks, burst_ticks);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_request(input logic [FLD_TIME_W-1:0] t, input logic [FLD_PORT_W-1:0] p,
			input logic [FLD_LEN_W-1:0] ofs, input logic [FLD_LEN_W-1:0] len);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		now_tick <= t;
		out_port <= p;
		offset_ticks <= ofs;
		burst_ticks <= len;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
	endtask

	// Hold off the sender until every owed grant has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (book.outstanding() != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
			input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		book.write_register(idx, data);
		if (last)
			cfg_valid <= 1'b0;
	endtask

	// One register setting, one idling mode, then random traffic
	task automatic run_phase(input logic [CFG_DATA_W-1:0] wl_data,
			input logic [CFG_DATA_W-1:0] guard_data, input int unsigned idle_pct,
			input int unsigned stall_pct, input bit stray_writes);
		int unsigned n, roll, step;
		logic [FLD_PORT_W-1:0] port;
		logic [FLD_LEN_W-1:0] ofs, len;
		wait_for_results();
		if (stray_writes) begin
			write_reg(REG_SPARE_LOW, 16'h1234, 1'b0);
			write_reg(REG_SPARE_TOP, 16'hFFFF, 1'b0);
		end
		write_reg(REG_WL_IN_USE, wl_data, 1'b0);
		write_reg(REG_GUARD, guard_data, 1'b1);
		sender_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		for (n = 0; n < PHASE_ITEMS; n++) begin
			roll = $urandom_range(99);
			if (roll < 1) begin
				// close to the top of the time range
				traffic_now = TIME_MAX[FLD_TIME_W-1:0] - FLD_TIME_W'($urandom_range(3000));
			end else if (roll < 4) begin
				// time steps back
				step = $urandom_range(5000);
				traffic_now = (traffic_now > step) ? traffic_now - step : '0;
			end else if (roll < 7) begin
				traffic_now = traffic_now + FLD_TIME_W'($urandom_range(1 << 20));
			end else begin
				traffic_now = traffic_now + FLD_TIME_W'($urandom_range(40));
			end
			// most traffic on two ports so channels pile up
			port = ($urandom_range(9) < 7) ? FLD_PORT_W'($urandom_range(1))
				: FLD_PORT_W'($urandom_range(7));
			ofs = ($urandom_range(19) == 0) ? FLD_LEN_W'($urandom)
				: FLD_LEN_W'($urandom_range(200));
			len = ($urandom_range(19) == 0) ? FLD_LEN_W'($urandom)
				: FLD_LEN_W'($urandom_range(1500));
			send_request(traffic_now, port, ofs, len);
			if ($urandom_range(49) == 0)
				wait_for_results();
		end
	endtask

	initial begin
		int w;
		book = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings, free channels, all-busy port, ties, extremes
		send_request(48'd0, 3'd0, 24'd0, 24'd0);
		send_request(48'd100, 3'd0, 24'd10, 24'd50);
		send_request(48'd120, 3'd0, 24'd5, 24'd20);
		for (w = 0; w < MAX_WL_DEF; w++)
			send_request(48'd1000, 3'd1, 24'd0, FLD_LEN_W'(300 + (w % 3) * 100));
		// every channel busy: earliest end wins, lowest on ties
		send_request(48'd1010, 3'd1, 24'd100, 24'd40);
		send_request(48'd1010, 3'd1, 24'hFFFFFF, 24'hFFFFFF);
		// time going backwards
		send_request(48'd500, 3'd1, 24'd0, 24'd10);
		// end time saturates
		send_request(48'hFFFF_FFFF_FFF0, 3'd7, 24'hFFFFFF, 24'hFFFFFF);
		send_request(48'hFFFF_FFFF_FFFF, 3'd7, 24'd0, 24'd0);
		send_request(48'h8000_0000_0000, 3'd2, 24'hAAAAAA, 24'h555555);
		send_request(48'h0000_0000_0001, 3'd6, 24'h555555, 24'hAAAAAA);

		// Random phases over register settings and idling modes
		traffic_now = 48'd2000;
		run_phase(16'hFFFF, 16'hFFFF, 0, 0, 1'b0);
		run_phase(16'd1, 16'd0, 76, 0, 1'b1);
		run_phase(16'd4, 16'd25, 0, 76, 1'b0);
		run_phase(16'hFFE0, 16'd3, 30, 30, 1'b0);
		run_phase(16'd9, 16'd500, 76, 76, 1'b0);
		run_phase(16'd16, 16'd0, 0, 0, 1'b0);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.failures() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/wcs_pkg.sv
rtl/wcs_cell.sv
rtl/wavelength_channel_scheduler.sv
tb/tb_top.sv
